### design/relative_error_norm_top_assert.svh
// assertion macros for the relative error norm block
`ifndef RELATIVE_ERROR_NORM_TOP_ASSERT_SVH
`define RELATIVE_ERROR_NORM_TOP_ASSERT_SVH

// consequent checked in the same cycle
`define REN_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("relative_error_norm assertion failed");

// consequent checked in the cycle after the antecedent
`define REN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("relative_error_norm assertion failed");

`endif

### design/ren_pkg.sv
// shared types and constants of the relative error norm block
`default_nettype none

package ren_pkg;

    localparam int DATA_W        = 24;
    localparam int TDATA_W       = 6 * DATA_W;
    localparam int RATIO_W       = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int KIND_W        = 2;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 2;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_NORM_KIND    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMPLEX_MODE = 2'd1;

    localparam logic [KIND_W-1:0] KIND_REL_MAX  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MAX_ZSUM = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REL_TWO  = 2'd2;

    localparam logic REQ_XY = 1'b0;
    localparam logic REQ_Z  = 1'b1;

    typedef struct packed {
        logic                     is_z;
        logic signed [DATA_W-1:0] a_re;
        logic signed [DATA_W-1:0] a_im;
        logic signed [DATA_W-1:0] b_re;
        logic signed [DATA_W-1:0] b_im;
        logic                     last;
    } ren_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } ren_q_stat_t;

endpackage

`default_nettype wire

### design/ren_front.sv
// front end: config registers, input transactions and operand selection
`default_nettype none

module ren_front import ren_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output      logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_axis_tvalid,
    output      logic                  s_axis_tready,
    input  wire logic [TDATA_W-1:0]    s_axis_tdata,
    input  wire logic                  s_axis_tuser,
    input  wire logic                  s_axis_tlast,
    input  wire ren_q_stat_t           q_stat,
    output      logic                  push,
    output      ren_item_t             item,
    output      logic [KIND_W-1:0]     norm_kind
);

    logic [KIND_W-1:0] norm_kind_reg, norm_kind_next;
    logic              complex_mode_reg, complex_mode_next;
    logic [DATA_W-1:0] x_re, x_im, y_re, y_im, z_re, z_im;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        norm_kind_next    = norm_kind_reg;
        complex_mode_next = complex_mode_reg;
        if (cfg_valid && cfg_index == REG_NORM_KIND)
        begin
            norm_kind_next = cfg_data;
        end
        if (cfg_valid && cfg_index == REG_COMPLEX_MODE)
        begin
            complex_mode_next = cfg_data[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            norm_kind_reg    <= KIND_REL_MAX;
            complex_mode_reg <= 1'b1;
        end
        else
        begin
            norm_kind_reg    <= norm_kind_next;
            complex_mode_reg <= complex_mode_next;
        end
    end

    assign x_re = s_axis_tdata[DATA_W-1:0];
    assign x_im = s_axis_tdata[2*DATA_W-1:DATA_W];
    assign y_re = s_axis_tdata[3*DATA_W-1:2*DATA_W];
    assign y_im = s_axis_tdata[4*DATA_W-1:3*DATA_W];
    assign z_re = s_axis_tdata[5*DATA_W-1:4*DATA_W];
    assign z_im = s_axis_tdata[6*DATA_W-1:5*DATA_W];

    // z items become a = z, b = 0; imaginary parts dropped in real mode
    always_comb
    begin
        item.is_z = (s_axis_tuser == REQ_Z);
        item.last = s_axis_tlast;
        if (s_axis_tuser == REQ_Z)
        begin
            item.a_re = z_re;
            item.a_im = complex_mode_reg ? z_im : '0;
            item.b_re = '0;
            item.b_im = '0;
        end
        else
        begin
            item.a_re = x_re;
            item.a_im = complex_mode_reg ? x_im : '0;
            item.b_re = y_re;
            item.b_im = complex_mode_reg ? y_im : '0;
        end
    end

    assign s_axis_tready = !q_stat.full;
    assign push          = s_axis_tvalid && !q_stat.full;
    assign norm_kind     = norm_kind_reg;

endmodule

`default_nettype wire

### design/ren_queue.sv
// short item queue between front and back
`default_nettype none

module ren_queue import ren_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire ren_item_t   push_item,
    input  wire logic        pop,
    output      ren_item_t   pop_item,
    output      ren_q_stat_t q_stat
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    ren_item_t              mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   do_push, do_pop;

    assign q_stat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign pop_item     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

### design/ren_back.sv
// back end: squares, accumulators, bit-serial root and divide, result register
`default_nettype none

module ren_back import ren_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ren_q_stat_t        q_stat,
    output      logic               pop,
    input  wire ren_item_t          item,
    input  wire logic [KIND_W-1:0]  norm_kind,
    output      logic               m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output      logic [RATIO_W-1:0] m_axis_tdata,
    output      logic [1:0]         m_axis_tuser
);

    localparam int MAG_W  = DATA_W + 1;
    localparam int PROD_W = 2 * MAG_W;
    localparam int DMAX_W = 50;
    localparam int RMAX_W = 48;
    localparam int SUM_W  = 64;
    localparam int ZSUM_W = 40;
    localparam int SH     = 2 * FRAC_BITS;
    localparam int W_SQ   = SUM_W + SH;
    localparam int W_R    = W_SQ / 2;
    localparam int CNT_W  = $clog2(W_SQ + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_ACC, S_SQRT, S_ZACC, S_LAST, S_DIV, S_FIN
    } state_t;

    state_t             state_reg, state_next;
    ren_item_t          item_reg, item_next;
    logic [MAG_W-1:0]   mag_reg [4];
    logic [MAG_W-1:0]   mag_next [4];
    logic [2:0]         step_reg, step_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [DMAX_W-1:0]  dsq_reg, dsq_next;
    logic [RMAX_W-1:0]  rsq_reg, rsq_next;
    logic [DMAX_W-1:0]  diff_max_reg, diff_max_next;
    logic [RMAX_W-1:0]  ref_max_reg, ref_max_next;
    logic [SUM_W-1:0]   diff_sum_reg, diff_sum_next;
    logic [SUM_W-1:0]   ref_sum_reg, ref_sum_next;
    logic [ZSUM_W-1:0]  z_sum_reg, z_sum_next;
    logic               sat_reg, sat_next;
    logic               kind1_reg, kind1_next;
    logic               fin_reg, fin_next;
    logic [W_SQ-1:0]    div_num_reg, div_num_next;
    logic [SUM_W-1:0]   div_rem_reg, div_rem_next;
    logic [SUM_W-1:0]   div_den_reg, div_den_next;
    logic [W_SQ-1:0]    sq_op_reg, sq_op_next;
    logic [W_R+1:0]     sq_rem_reg, sq_rem_next;
    logic [W_R-1:0]     sq_root_reg, sq_root_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [W_SQ-1:0]    res_reg, res_next;
    logic               zero_reg, zero_next;
    logic               out_valid_reg, out_valid_next;
    logic [RATIO_W-1:0] ratio_reg, ratio_next;
    logic               out_zero_reg, out_zero_next;
    logic               out_ovf_reg, out_ovf_next;

    logic [MAG_W-1:0]   d_re, d_im, mag_sel;
    logic [SUM_W:0]     dsum_add, rsum_add;
    logic [ZSUM_W:0]    zsum_add;
    logic [SUM_W:0]     div_sh;
    logic               div_bit;
    logic [W_SQ-1:0]    div_step_num;
    logic [SUM_W-1:0]   div_step_rem;
    logic [W_R+3:0]     sq_rem2, sq_trial;
    logic               sq_bit;
    logic [W_R+1:0]     sq_step_rem;
    logic [W_R-1:0]     sq_step_root;
    logic [KIND_W-1:0]  kind_eff;
    logic [SUM_W-1:0]   num_sel, den_sel;
    logic               res_big;

    function automatic logic [MAG_W-1:0] abs_mag(input logic [MAG_W-1:0] v);
        return v[MAG_W-1] ? (~v + 1'b1) : v;
    endfunction

    assign d_re    = {item.a_re[DATA_W-1], item.a_re} - {item.b_re[DATA_W-1], item.b_re};
    assign d_im    = {item.a_im[DATA_W-1], item.a_im} - {item.b_im[DATA_W-1], item.b_im};
    assign mag_sel = mag_reg[step_reg[1:0]];

    assign dsum_add = {1'b0, diff_sum_reg} + (SUM_W + 1)'(dsq_reg);
    assign rsum_add = {1'b0, ref_sum_reg} + (SUM_W + 1)'(rsq_reg);
    assign zsum_add = {1'b0, z_sum_reg} + (ZSUM_W + 1)'(sq_root_reg[DATA_W-1:0]);

    // restoring divide, one quotient bit per cycle
    assign div_sh       = {div_rem_reg, div_num_reg[W_SQ-1]};
    assign div_bit      = (div_sh >= {1'b0, div_den_reg});
    assign div_step_rem = div_bit ? SUM_W'(div_sh - {1'b0, div_den_reg}) : div_sh[SUM_W-1:0];
    assign div_step_num = {div_num_reg[W_SQ-2:0], div_bit};

    // digit-by-digit square root, one root bit per cycle
    assign sq_rem2      = {sq_rem_reg, sq_op_reg[W_SQ-1:W_SQ-2]};
    assign sq_trial     = (W_R + 4)'({sq_root_reg, 2'b01});
    assign sq_bit       = (sq_rem2 >= sq_trial);
    assign sq_step_rem  = sq_bit ? (W_R + 2)'(sq_rem2 - sq_trial) : sq_rem2[W_R+1:0];
    assign sq_step_root = {sq_root_reg[W_R-2:0], sq_bit};

    assign kind_eff = (norm_kind == KIND_MAX_ZSUM || norm_kind == KIND_REL_TWO)
                      ? norm_kind : KIND_REL_MAX;
    assign num_sel  = (kind_eff == KIND_REL_MAX) ? SUM_W'(diff_max_reg) : diff_sum_reg;
    assign den_sel  = (kind_eff == KIND_REL_MAX) ? SUM_W'(ref_max_reg) : ref_sum_reg;
    assign res_big  = |res_reg[W_SQ-1:RATIO_W];

    assign pop = (state_reg == S_IDLE) && !q_stat.empty;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        mag_next       = mag_reg;
        step_next      = step_reg;
        prod_next      = mag_sel * mag_sel;
        dsq_next       = dsq_reg;
        rsq_next       = rsq_reg;
        diff_max_next  = diff_max_reg;
        ref_max_next   = ref_max_reg;
        diff_sum_next  = diff_sum_reg;
        ref_sum_next   = ref_sum_reg;
        z_sum_next     = z_sum_reg;
        sat_next       = sat_reg;
        kind1_next     = kind1_reg;
        fin_next       = fin_reg;
        div_num_next   = div_num_reg;
        div_rem_next   = div_rem_reg;
        div_den_next   = div_den_reg;
        sq_op_next     = sq_op_reg;
        sq_rem_next    = sq_rem_reg;
        sq_root_next   = sq_root_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        zero_next      = zero_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        ratio_next     = ratio_reg;
        out_zero_next  = out_zero_reg;
        out_ovf_next   = out_ovf_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    item_next   = item;
                    mag_next[0] = abs_mag(d_re);
                    mag_next[1] = abs_mag(d_im);
                    mag_next[2] = abs_mag({item.a_re[DATA_W-1], item.a_re});
                    mag_next[3] = abs_mag({item.a_im[DATA_W-1], item.a_im});
                    step_next   = '0;
                    dsq_next    = '0;
                    rsq_next    = '0;
                    state_next  = S_MUL;
                end
            end
            S_MUL:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == 3'd1 || step_reg == 3'd2)
                begin
                    dsq_next = dsq_reg + prod_reg;
                end
                if (step_reg == 3'd3 || step_reg == 3'd4)
                begin
                    rsq_next = rsq_reg + prod_reg[RMAX_W-1:0];
                end
                if (step_reg == 3'd4)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                if (item_reg.is_z)
                begin
                    sq_op_next   = W_SQ'(rsq_reg);
                    sq_rem_next  = '0;
                    sq_root_next = '0;
                    cnt_next     = CNT_W'(W_R);
                    fin_next     = 1'b0;
                    state_next   = S_SQRT;
                end
                else
                begin
                    if (dsq_reg > diff_max_reg)
                    begin
                        diff_max_next = dsq_reg;
                    end
                    if (rsq_reg > ref_max_reg)
                    begin
                        ref_max_next = rsq_reg;
                    end
                    if (dsum_add[SUM_W])
                    begin
                        diff_sum_next = '1;
                        sat_next      = 1'b1;
                    end
                    else
                    begin
                        diff_sum_next = dsum_add[SUM_W-1:0];
                    end
                    if (rsum_add[SUM_W])
                    begin
                        ref_sum_next = '1;
                        sat_next     = 1'b1;
                    end
                    else
                    begin
                        ref_sum_next = rsum_add[SUM_W-1:0];
                    end
                    state_next = item_reg.last ? S_LAST : S_IDLE;
                end
            end
            S_ZACC:
            begin
                if (zsum_add[ZSUM_W])
                begin
                    z_sum_next = '1;
                    sat_next   = 1'b1;
                end
                else
                begin
                    z_sum_next = zsum_add[ZSUM_W-1:0];
                end
                state_next = item_reg.last ? S_LAST : S_IDLE;
            end
            S_LAST:
            begin
                fin_next   = 1'b1;
                zero_next  = 1'b0;
                res_next   = '0;
                kind1_next = (kind_eff == KIND_MAX_ZSUM);
                if (kind_eff == KIND_MAX_ZSUM)
                begin
                    if (z_sum_reg == '0)
                    begin
                        zero_next  = 1'b1;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        sq_op_next   = {(SUM_W - DMAX_W)'(0), diff_max_reg, SH'(0)};
                        sq_rem_next  = '0;
                        sq_root_next = '0;
                        cnt_next     = CNT_W'(W_R);
                        state_next   = S_SQRT;
                    end
                end
                else
                begin
                    if (den_sel == '0)
                    begin
                        zero_next  = 1'b1;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        div_num_next = {num_sel, SH'(0)};
                        div_rem_next = '0;
                        div_den_next = den_sel;
                        cnt_next     = CNT_W'(W_SQ);
                        state_next   = S_DIV;
                    end
                end
            end
            S_SQRT:
            begin
                sq_op_next   = {sq_op_reg[W_SQ-3:0], 2'b00};
                sq_rem_next  = sq_step_rem;
                sq_root_next = sq_step_root;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    if (!fin_reg)
                    begin
                        state_next = S_ZACC;
                    end
                    else if (kind1_reg)
                    begin
                        div_num_next = W_SQ'(sq_step_root);
                        div_rem_next = '0;
                        div_den_next = SUM_W'(z_sum_reg);
                        cnt_next     = CNT_W'(W_SQ);
                        state_next   = S_DIV;
                    end
                    else
                    begin
                        res_next   = W_SQ'(sq_step_root);
                        state_next = S_FIN;
                    end
                end
            end
            S_DIV:
            begin
                div_num_next = div_step_num;
                div_rem_next = div_step_rem;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    if (kind1_reg)
                    begin
                        res_next   = div_step_num;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        sq_op_next   = div_step_num;
                        sq_rem_next  = '0;
                        sq_root_next = '0;
                        cnt_next     = CNT_W'(W_R);
                        state_next   = S_SQRT;
                    end
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    ratio_next     = res_big ? '1 : res_reg[RATIO_W-1:0];
                    out_zero_next  = zero_reg;
                    out_ovf_next   = res_big || sat_reg;
                    diff_max_next  = '0;
                    ref_max_next   = '0;
                    diff_sum_next  = '0;
                    ref_sum_next   = '0;
                    z_sum_next     = '0;
                    sat_next       = 1'b0;
                    fin_next       = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            diff_max_reg  <= '0;
            ref_max_reg   <= '0;
            diff_sum_reg  <= '0;
            ref_sum_reg   <= '0;
            z_sum_reg     <= '0;
            sat_reg       <= 1'b0;
            kind1_reg     <= 1'b0;
            fin_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            diff_max_reg  <= diff_max_next;
            ref_max_reg   <= ref_max_next;
            diff_sum_reg  <= diff_sum_next;
            ref_sum_reg   <= ref_sum_next;
            z_sum_reg     <= z_sum_next;
            sat_reg       <= sat_next;
            kind1_reg     <= kind1_next;
            fin_reg       <= fin_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        mag_reg      <= mag_next;
        prod_reg     <= prod_next;
        dsq_reg      <= dsq_next;
        rsq_reg      <= rsq_next;
        div_num_reg  <= div_num_next;
        div_rem_reg  <= div_rem_next;
        div_den_reg  <= div_den_next;
        sq_op_reg    <= sq_op_next;
        sq_rem_reg   <= sq_rem_next;
        sq_root_reg  <= sq_root_next;
        res_reg      <= res_next;
        zero_reg     <= zero_next;
        ratio_reg    <= ratio_next;
        out_zero_reg <= out_zero_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = ratio_reg;
    assign m_axis_tuser  = {out_ovf_reg, out_zero_reg};

endmodule

`default_nettype wire

### design/relative_error_norm_top.sv
// top level of the relative error norm block
`default_nettype none

// Relative error norm: x/y pairs and z elements stream in, and the transaction
// with tlast set produces one unsigned Q(32-FRAC_BITS).FRAC_BITS ratio. An x/y
// element passes through a shared 25x25 squarer used four times in the back end,
// then the accumulate step; a z element also passes through a bit-serial root
// of its magnitude. The result adds one bit-serial divide and one bit-serial
// root unless its denominator is zero. A two-entry queue lets the input side
// run ahead, and the result register lets the next job proceed while a result
// waits.

`include "relative_error_norm_top_assert.svh"

module relative_error_norm_top import ren_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output      logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_axis_tvalid,
    output      logic                  s_axis_tready,
    // x_re, x_im, y_re, y_im, z_re, z_im
    input  wire logic [TDATA_W-1:0]    s_axis_tdata,
    // req_type
    input  wire logic                  s_axis_tuser,
    input  wire logic                  s_axis_tlast,
    output      logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // ratio
    output      logic [RATIO_W-1:0]    m_axis_tdata,
    // zero_denominator, overflowed
    output      logic [1:0]            m_axis_tuser
);

    ren_q_stat_t       q_stat;
    logic              push;
    logic              pop;
    ren_item_t         push_item;
    ren_item_t         pop_item;
    logic [KIND_W-1:0] norm_kind;

    ren_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .q_stat        (q_stat),
        .push          (push),
        .item          (push_item),
        .norm_kind     (norm_kind)
    );

    ren_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .q_stat    (q_stat)
    );

    ren_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_stat        (q_stat),
        .pop           (pop),
        .item          (pop_item),
        .norm_kind     (norm_kind),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    `REN_ASSERT_SAME(a_zero_den_ratio, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0)
    `REN_ASSERT_NEXT(a_push_fills_queue, push, !q_stat.empty)
    `REN_ASSERT_SAME(a_no_pop_when_empty, q_stat.empty, !pop)

endmodule

`default_nettype wire
